@@ rtl/bldc_commutation_timing_sequencer_core_macros.svh @@
// Assertion macros shared by the sequencer RTL.
// Define ASSERT_OFF to compile them out.
`ifndef BLDC_COMMUTATION_TIMING_SEQUENCER_CORE_MACROS_SVH
`define BLDC_COMMUTATION_TIMING_SEQUENCER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// pre holds -> post holds in the same cycle
`define BCT_ASSERT_IMPLY(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("bct assertion failed: same-cycle implication");

// pre holds -> post holds in the next cycle
`define BCT_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("bct assertion failed: next-cycle implication");

// cond never holds
`define BCT_ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("bct assertion failed: forbidden condition");

`else

`define BCT_ASSERT_IMPLY(name, clk, rst_n, pre, post)
`define BCT_ASSERT_NEXT(name, clk, rst_n, pre, post)
`define BCT_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

@@ rtl/bct_pkg.sv @@
package bct_pkg;

	// event commands
	typedef enum logic [1:0] {
		CMD_EDGE      = 2'd0,
		CMD_MATCH     = 2'd1,
		CMD_SET_PHASE = 2'd2,
		CMD_ARM_PURE  = 2'd3
	} cmd_t;

	// actions reported per word
	typedef enum logic [1:0] {
		ACT_NONE     = 2'd0,
		ACT_COMMUTE  = 2'd1,
		ACT_STEP     = 2'd2,
		ACT_FALSE    = 2'd3
	} action_t;

	// edge sensing control
	typedef enum logic [1:0] {
		SENSE_KEEP = 2'd0,
		SENSE_OFF  = 2'd1,
		SENSE_ON   = 2'd2,
		SENSE_RSVD = 2'd3
	} sense_t;

	// commutation phase states
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_COMMUTE = 2'd1,
		PH_HALF    = 2'd2,
		PH_THIRD   = 2'd3
	} phase_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REC,
		ST_SCAN,
		ST_DRAIN,
		ST_DIV,
		ST_DONE
	} state_t;

	localparam int unsigned TW = 16;

	// floor(p/3) = (p * 43691) >> 17 for any 16-bit p
	localparam logic [16:0] THIRD_MULT  = 17'd43691;
	localparam int unsigned THIRD_SHIFT = 17;

	// pure-control count limit
	localparam logic [1:0] PURE_MAX  = 2'd3;
	localparam logic [1:0] PURE_STOP = 2'd2;

	typedef struct packed {
		logic load;
		logic rec;
		logic scan;
		logic div;
		logic commit;
	} bct_cmd_t;

	typedef struct packed {
		logic evt_edge;
		logic cand_last;
		logic out_free;
	} bct_sts_t;

endpackage

@@ rtl/bct_if.sv @@
// event channel
interface bct_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] timer_now;
	logic [1:0]  new_state;

	modport source (output valid, output cmd, output timer_now, output new_state,
		input ready);
	modport sink (input valid, input cmd, input timer_now, input new_state,
		output ready);
endinterface

// result channel
interface bct_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [1:0]  sense_control;
	logic        compare_written;
	logic [15:0] compare_time;
	logic        compare_armed;
	logic [15:0] period_estimate;
	logic [1:0]  phase_now;

	modport source (output valid, output action, output sense_control,
		output compare_written, output compare_time, output compare_armed,
		output period_estimate, output phase_now, input ready);
	modport sink (input valid, input action, input sense_control,
		input compare_written, input compare_time, input compare_armed,
		input period_estimate, input phase_now, output ready);
endinterface

@@ rtl/bct_ctrl.sv @@
module bct_ctrl import bct_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     evt_valid,
	output logic     evt_ready,
	input  bct_sts_t sts,
	output bct_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (evt_valid) begin
					state_d = sts.evt_edge ? ST_REC : ST_DONE;
				end
			end
			ST_REC:   state_d = ST_SCAN;
			ST_SCAN: begin
				if (sts.cand_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DIV;
			ST_DIV:   state_d = ST_DONE;
			ST_DONE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		evt_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				evt_ready = 1'b1;
				cmd.load  = evt_valid;
			end
			ST_REC:   cmd.rec    = 1'b1;
			ST_SCAN:  cmd.scan   = 1'b1;
			ST_DRAIN: cmd        = '0;
			ST_DIV:   cmd.div    = 1'b1;
			ST_DONE:  cmd.commit = sts.out_free;
			default:  cmd        = '0;
		endcase
	end

endmodule

@@ rtl/bct_dp.sv @@
`include "bldc_commutation_timing_sequencer_core_macros.svh"

module bct_dp import bct_pkg::*; #(
	parameter int unsigned RING_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  bct_cmd_t    cmd,
	output bct_sts_t    sts,
	input  logic [1:0]  evt_cmd,
	input  logic [15:0] evt_timer_now,
	input  logic [1:0]  evt_new_state,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  res_action,
	output logic [1:0]  res_sense_control,
	output logic        res_compare_written,
	output logic [15:0] res_compare_time,
	output logic        res_compare_armed,
	output logic [15:0] res_period_estimate,
	output logic [1:0]  res_phase_now
);

	localparam int unsigned IW      = $clog2(RING_DEPTH);
	localparam int unsigned CW      = $clog2(RING_DEPTH + 1);
	localparam int unsigned MED_POS = RING_DEPTH / 2;
	localparam logic [IW-1:0] IDX_LAST = IW'(RING_DEPTH - 1);

	// captured event
	logic [1:0]    ecmd_q;
	logic [TW-1:0] now_q;
	logic [1:0]    ns_q;

	// period history and estimate
	logic [TW-1:0] ring_q [RING_DEPTH];
	logic [IW-1:0] idx_q;
	logic [TW-1:0] last_q;
	logic [TW-1:0] median_q;
	logic [TW-1:0] third_q;

	// phase state
	logic [1:0] phase_q;
	logic       pure_q;
	logic [1:0] pcnt_q;
	logic       cen_q;

	// median search pipeline
	logic [IW-1:0]         cand_q;
	logic                  valid_s1;
	logic [TW-1:0]         cand_s1;
	logic [RING_DEPTH-1:0] lt_s1;
	logic [RING_DEPTH-1:0] le_s1;

	// result register
	logic          ovalid_q;
	logic [1:0]    oact_q;
	logic [1:0]    osense_q;
	logic          owr_q;
	logic [TW-1:0] otime_q;
	logic          oarm_q;
	logic [TW-1:0] oper_q;
	logic [1:0]    ophase_q;

	logic          out_free;
	logic [TW-1:0] diff;
	logic [IW-1:0] idx_nxt;
	logic [TW-1:0] cand_val;
	logic [CW-1:0] lt_cnt;
	logic [CW-1:0] le_cnt;
	logic          med_hit;
	logic [32:0]   third_prod;

	// commit results
	logic [1:0]    act_c;
	logic [1:0]    sense_c;
	logic          wr_c;
	logic [TW-1:0] add_c;
	logic [TW-1:0] time_c;
	logic [1:0]    phase_c;
	logic          cen_c;
	logic          pure_c;
	logic [1:0]    pcnt_c;
	logic [1:0]    pinc;

	assign out_free = !ovalid_q || res_ready;

	assign sts.evt_edge  = (evt_cmd == CMD_EDGE);
	assign sts.cand_last = (cand_q == IDX_LAST);
	assign sts.out_free  = out_free;

	// |now - last| as a plain unsigned distance, no wrap correction
	assign diff    = (now_q > last_q) ? (now_q - last_q) : (last_q - now_q);
	assign idx_nxt = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;

	assign cand_val = ring_q[cand_q];

	// upper median: the value with lt <= MED_POS < le
	assign lt_cnt  = CW'($countones(lt_s1));
	assign le_cnt  = CW'($countones(le_s1));
	assign med_hit = valid_s1 && (lt_cnt <= CW'(MED_POS)) && (CW'(MED_POS) < le_cnt);

	assign third_prod = {17'd0, median_q} * {16'd0, THIRD_MULT};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ecmd_q <= evt_cmd;
			now_q  <= evt_timer_now;
			ns_q   <= evt_new_state;
		end
		if (cmd.scan) begin
			cand_s1 <= cand_val;
			for (int j = 0; j < RING_DEPTH; j++) begin
				lt_s1[j] <= ring_q[j] < cand_val;
				le_s1[j] <= ring_q[j] <= cand_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			idx_q    <= '0;
			last_q   <= '0;
			median_q <= '0;
			third_q  <= '0;
			cand_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan;
			if (cmd.rec) begin
				ring_q[idx_nxt] <= diff;
				idx_q           <= idx_nxt;
				last_q          <= now_q;
				cand_q          <= '0;
			end else if (cmd.scan) begin
				cand_q <= (cand_q == IDX_LAST) ? '0 : cand_q + 1'b1;
			end
			if (med_hit) begin
				median_q <= cand_s1;
			end
			if (cmd.div) begin
				third_q <= third_prod[THIRD_SHIFT +: TW];
			end
		end
	end

	always_comb begin
		act_c   = ACT_NONE;
		sense_c = SENSE_KEEP;
		wr_c    = 1'b0;
		add_c   = '0;
		phase_c = phase_q;
		cen_c   = cen_q;
		pure_c  = pure_q;
		pcnt_c  = pcnt_q;
		pinc    = (pcnt_q < PURE_MAX) ? pcnt_q + 2'd1 : pcnt_q;
		case (ecmd_q)
			CMD_EDGE: begin
				sense_c = SENSE_OFF;
				if (phase_q != PH_IDLE) begin
					phase_c = PH_HALF;
					cen_c   = 1'b1;
					wr_c    = 1'b1;
					add_c   = median_q >> 1;
				end
			end
			CMD_MATCH: begin
				cen_c = 1'b0;
				case (phase_q)
					PH_COMMUTE: begin
						sense_c = SENSE_OFF;
						act_c   = ACT_COMMUTE;
					end
					PH_HALF: begin
						phase_c = PH_THIRD;
						if (pure_q) begin
							act_c  = ACT_FALSE;
							pcnt_c = pinc;
							if (pinc > PURE_STOP) begin
								pure_c = 1'b0;
							end
						end else begin
							act_c = ACT_STEP;
						end
						cen_c = 1'b1;
						wr_c  = 1'b1;
						add_c = third_q;
					end
					default: begin
						phase_c = PH_COMMUTE;
						sense_c = SENSE_ON;
						cen_c   = 1'b1;
						wr_c    = 1'b1;
						add_c   = median_q + (median_q << 1);
					end
				endcase
			end
			CMD_SET_PHASE: phase_c = ns_q;
			default: begin
				pure_c = 1'b1;
				pcnt_c = '0;
			end
		endcase
		time_c = wr_c ? now_q + add_c : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pure_q   <= 1'b0;
			pcnt_q   <= '0;
			cen_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				phase_q  <= phase_c;
				pure_q   <= pure_c;
				pcnt_q   <= pcnt_c;
				cen_q    <= cen_c;
				ovalid_q <= 1'b1;
			end else if (res_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			oact_q   <= act_c;
			osense_q <= sense_c;
			owr_q    <= wr_c;
			otime_q  <= time_c;
			oarm_q   <= cen_c;
			oper_q   <= median_q;
			ophase_q <= phase_c;
		end
	end

	assign res_valid           = ovalid_q;
	assign res_action          = oact_q;
	assign res_sense_control   = osense_q;
	assign res_compare_written = owr_q;
	assign res_compare_time    = otime_q;
	assign res_compare_armed   = oarm_q;
	assign res_period_estimate = oper_q;
	assign res_phase_now       = ophase_q;

	`BCT_ASSERT_IMPLY(a_commit_slot, clk, arst_n, cmd.commit, !ovalid_q || res_ready)
	`BCT_ASSERT_NEXT(a_commit_shows, clk, arst_n, cmd.commit, ovalid_q)
	`BCT_ASSERT_IMPLY(a_time_zero, clk, arst_n, ovalid_q && !owr_q, otime_q == '0)
	`BCT_ASSERT_NEVER(a_pure_limit, clk, arst_n, pure_q && (pcnt_q == PURE_MAX))
	`BCT_ASSERT_NEVER(a_idx_range, clk, arst_n, idx_q > IDX_LAST)

endmodule

@@ rtl/bldc_commutation_timing_sequencer_core.sv @@
// Timing: an edge word passes REC, SCAN, DRAIN, DIV and DONE between accept and result,
// the median scan visiting one ring entry per cycle; any other word goes from IDLE to DONE.
// Flow: one word at a time; a new word is taken only once the last one is committed;
// a result waiting in the output register delays only the commit of the next word, not its
// accept.
// Reset: arst_n asynchronous, active low; ring, period, phase and flags clear to zero.
module bldc_commutation_timing_sequencer_core import bct_pkg::*; #(
	parameter int unsigned RING_DEPTH = 8
) (
	input logic clk,
	input logic arst_n,
	bct_in_if.sink    evt,
	bct_out_if.source res
);

	// Controller <-> datapath command and status.
	bct_cmd_t cmd;
	bct_sts_t sts;

	// Sequencer:
	//   IDLE  - takes a word; edges go through the period path, other words
	//           go straight to commit.
	//   REC   - stores |now - last edge| in the next ring slot.
	//   SCAN  - one candidate per cycle: compare against every slot, count
	//           smaller and smaller-or-equal entries one stage later.
	//   DRAIN - last candidate leaves the count stage.
	//   DIV   - period/3 via reciprocal multiply, registered.
	//   DONE  - phase update, compare scheduling, result loaded once the
	//           output register is free.
	bct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: event capture, period ring, median search, phase logic and
	// the result register facing the output channel.
	bct_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.evt_cmd             (evt.cmd),
		.evt_timer_now       (evt.timer_now),
		.evt_new_state       (evt.new_state),
		.res_valid           (res.valid),
		.res_ready           (res.ready),
		.res_action          (res.action),
		.res_sense_control   (res.sense_control),
		.res_compare_written (res.compare_written),
		.res_compare_time    (res.compare_time),
		.res_compare_armed   (res.compare_armed),
		.res_period_estimate (res.period_estimate),
		.res_phase_now       (res.phase_now)
	);

endmodule
